>>> design/lwcrm_pkg.sv
// Package with shared constants, types and the controller interface structs.
`timescale 1ns / 1ps
package lwcrm_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int TOTAL_BITS  = $clog2(STORE_DEPTH + 1);
    localparam int MED_BITS    = COUNT_BITS + 1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_FF      = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] CH_DASH    = 8'd45;
    localparam logic [7:0] CH_QUERY   = 8'd63;
    localparam logic [7:0] CH_COMMA   = 8'd44;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [MED_BITS-1:0]   median_t;
    typedef logic [TOTAL_BITS-1:0] total_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic latch_line;
        logic scan_rd;
        logic shift_wr;
        logic ins_wr;
        logic med_rd_hi;
        logic med_rd_lo;
        logic out_load;
    } lwcrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   newline;
        logic   store_full;
        logic   total_zero;
        logic   k_one;
        logic   ge;
        logic   out_free;
        total_t total;
    } lwcrm_stat_t;

endpackage

>>> design/lwcrm_if.sv
// Stream interfaces for the text byte input and the result output.
`timescale 1ns / 1ps
interface lwcrm_in_if;
    import lwcrm_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface lwcrm_out_if;
    import lwcrm_pkg::*;
    logic    valid;
    logic    ready;
    median_t median_doubled;
    count_t  line_words;
    logic    store_full;

    modport source (output valid, output median_doubled, output line_words,
                    output store_full, input ready);
    modport sink (input valid, input median_doubled, input line_words,
                  input store_full, output ready);
endinterface

>>> design/line_word_count_running_median.sv
// Top level: running median of per-line word counts.
// On a newline the line's count is latched; each stored count not below it is read and shifted up,
// then the new count is inserted (a full store skips the insertion). The two middle entries are then
// read and the result is loaded once the output register is free.
// Throughput: one byte per cycle; intake then stops from a newline until its result is loaded,
// set by the single read port of the store. Reset clears counters and fill count at once.
`timescale 1ns / 1ps
module line_word_count_running_median (
    input logic        clk,
    input logic        rst_n,
    lwcrm_in_if.sink   in_ch,
    lwcrm_out_if.source out_ch
);
    import lwcrm_pkg::*;

    lwcrm_cmd_t  cmd;
    lwcrm_stat_t st;

    lwcrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    lwcrm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_byte      (in_ch.text_byte),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .median_doubled (out_ch.median_doubled),
        .line_words     (out_ch.line_words),
        .store_full     (out_ch.store_full)
    );

`ifndef SYNTHESIS
    // The fill count never passes the store depth.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st.total <= total_t'(STORE_DEPTH))
        else $error("store fill count above depth");

    // A newline beat stops intake for the insertion.
    a_newline_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.text_byte == CH_NEWLINE) |=> !in_ch.ready)
        else $error("input taken during insertion");

    // A full flag on a new result means the store is at capacity.
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load) |=> (!out_ch.store_full || st.total == total_t'(STORE_DEPTH)))
        else $error("full flag with store not full");
`endif

endmodule

>>> design/lwcrm_ctrl.sv
// Controller state machine for line insertion and median readout.
`timescale 1ns / 1ps
module lwcrm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lwcrm_pkg::lwcrm_stat_t st,
    output lwcrm_pkg::lwcrm_cmd_t  cmd
);
    import lwcrm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CMP = 7'b0000100,
        S_INS      = 7'b0001000,
        S_MED_HI   = 7'b0010000,
        S_MED_LO   = 7'b0100000,
        S_MED_SUM  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.take   = in_valid && in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && st.newline)
                begin
                    cmd.latch_line = 1'b1;
                    if (st.store_full)
                    begin
                        state_next = S_MED_HI;
                    end
                    else if (st.total_zero)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (st.ge)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next   = st.k_one ? S_INS : S_SCAN_RD;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_MED_HI;
            end
            S_MED_HI:
            begin
                cmd.med_rd_hi = 1'b1;
                state_next    = S_MED_LO;
            end
            S_MED_LO:
            begin
                cmd.med_rd_lo = 1'b1;
                state_next    = S_MED_SUM;
            end
            S_MED_SUM:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/lwcrm_dp.sv
// Datapath: word counting, sorted count memory, median and output register.
`timescale 1ns / 1ps
module lwcrm_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             text_byte,
    input  lwcrm_pkg::lwcrm_cmd_t  cmd,
    output lwcrm_pkg::lwcrm_stat_t st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lwcrm_pkg::median_t     median_doubled,
    output lwcrm_pkg::count_t      line_words,
    output logic                   store_full
);
    import lwcrm_pkg::*;

    localparam total_t DEPTH_T = total_t'(STORE_DEPTH);

    count_t  mem [STORE_DEPTH];
    count_t  rdata_reg;
    count_t  acc_reg;
    count_t  cur_reg;
    logic    inword_reg;
    total_t  total_reg;
    total_t  k_reg;
    count_t  value_reg;
    logic    full_reg;
    logic    out_valid_reg;
    median_t med_out_reg;
    count_t  words_out_reg;
    logic    full_out_reg;

    logic    is_blank;
    logic    is_ignored;
    logic    wr_en;
    count_t  wr_data;
    logic    rd_en;
    total_t  half_n;
    total_t  rd_idx;
    median_t median_now;

    assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                      (text_byte == CH_VT) || (text_byte == CH_FF) ||
                      (text_byte == CH_CR);
    assign is_ignored = (text_byte == CH_DOT) || (text_byte == CH_DASH) ||
                        (text_byte == CH_QUERY) || (text_byte == CH_COMMA);

    // Status towards the controller.
    assign st.newline    = (text_byte == CH_NEWLINE);
    assign st.store_full = (total_reg == DEPTH_T);
    assign st.total_zero = (total_reg == '0);
    assign st.k_one      = (k_reg == total_t'(1));
    assign st.ge         = (rdata_reg >= value_reg);
    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.total      = total_reg;

    // Memory port selection.
    assign half_n  = total_reg >> 1;
    assign rd_en   = cmd.scan_rd || cmd.med_rd_hi || cmd.med_rd_lo;
    assign wr_en   = cmd.shift_wr || cmd.ins_wr;
    assign wr_data = cmd.shift_wr ? rdata_reg : value_reg;

    always_comb
    begin
        if (cmd.scan_rd)
        begin
            rd_idx = k_reg - total_t'(1);
        end
        else if (cmd.med_rd_hi)
        begin
            rd_idx = half_n;
        end
        else
        begin
            rd_idx = half_n - total_t'(1);
        end
    end

    // Sorted count store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[k_reg[ADDR_BITS-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx[ADDR_BITS-1:0]];
        end
    end

    // Upper middle entry is held while the lower one is read.
    always_ff @(posedge clk)
    begin
        if (cmd.med_rd_lo)
        begin
            acc_reg <= rdata_reg;
        end
    end

    // Line word counter and insertion control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            inword_reg <= 1'b0;
            total_reg  <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.latch_line)
            begin
                cur_reg    <= '0;
                inword_reg <= 1'b0;
                k_reg      <= total_reg;
            end
            else if (cmd.take && !is_ignored)
            begin
                if (is_blank)
                begin
                    inword_reg <= 1'b0;
                end
                else if (!inword_reg)
                begin
                    inword_reg <= 1'b1;
                    if (!(&cur_reg))
                    begin
                        cur_reg <= cur_reg + count_t'(1);
                    end
                end
            end
            if (cmd.shift_wr)
            begin
                k_reg <= k_reg - total_t'(1);
            end
            if (cmd.ins_wr)
            begin
                total_reg <= total_reg + total_t'(1);
            end
        end
    end

    // Values captured at the end of a line.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_line)
        begin
            value_reg <= cur_reg;
            full_reg  <= st.store_full;
        end
    end

    // Median from one or two middle entries.
    assign median_now = total_reg[0] ? {acc_reg, 1'b0}
                                     : (median_t'(acc_reg) + median_t'(rdata_reg));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            med_out_reg   <= median_now;
            words_out_reg <= value_reg;
            full_out_reg  <= full_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = med_out_reg;
    assign line_words     = words_out_reg;
    assign store_full     = full_out_reg;

endmodule
